FILE: hw/rtl/note_segmenter_from_pitch_frames_core_defines.svh
// Assertion macros for the note segmenter.
// Included by the top level only; depends on nothing else.
`ifndef NOTE_SEGMENTER_FROM_PITCH_FRAMES_CORE_DEFINES_SVH
`define NOTE_SEGMENTER_FROM_PITCH_FRAMES_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nsf_pkg.sv
// Shared types and constants of the note segmenter.
// Used by every RTL module; depends on nothing.
package nsf_pkg;

  localparam int COUNT_BITS = 16;
  localparam int STAMP_BITS = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [7:0] THRESHOLD_RESET = 8'd153;
  localparam logic [15:0] MIN_FRAMES_RESET = 16'd10;
  localparam logic [7:0] MIDI_OFFSET = 8'd84;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MIN_FRAMES = 2'd1;

  // Mantissa thresholds in Q1.16 for rounding to the nearest semitone.
  localparam logic [16:0] SEMI_EDGE [12] = '{
    17'd68939, 17'd73039, 17'd77382, 17'd81983, 17'd86858, 17'd92023,
    17'd97495, 17'd103292, 17'd109434, 17'd115941, 17'd122835, 17'd130139
  };

  typedef struct packed {
    logic [STAMP_BITS-1:0] start_stamp;
    logic [31:0]           stop_stamp;
    logic [31:0]           pitch_sum;
    logic [COUNT_BITS-1:0] voiced_count;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_FIN
  } back_state_e;

endpackage

FILE: hw/rtl/note_segmenter_from_pitch_frames_core.sv
// Top level of the note segmenter: front end, job queue and back end.
// Depends on nsf_pkg, nsf_front, nsf_queue, nsf_back and the defines header.
//
// Usage: pitch frames enter on the input valid/ready channel, one transaction
// per frame (time stamp, Q12.4 pitch, Q0.8 confidence). Finished notes leave
// on the output valid/ready channel, one transaction per note with start and
// end stamps, truncated mean pitch and the nearest MIDI note number.
// Configuration is a plain write port: index 0 is the confidence threshold,
// index 1 the minimum frame count; write it only while the block is idle.
// Throughput: the front end takes one frame per cycle while the job queue
// has room. A frame that closes a note queues one job; the back end fetches
// it, runs it through the bit-serial divider and the normalizing shifter,
// loads the output register and only then fetches the next job. When the
// receiver stalls, the result waits in the output register, the back end
// holds its next job, and once the queue of two jobs is full the input ready
// drops. Reset restores the default configuration, closes any open run and
// empties the queue and output.
`include "note_segmenter_from_pitch_frames_core_defines.svh"

module note_segmenter_from_pitch_frames_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] frame_time_i,
  input  logic [15:0] pitch_q4_i,
  input  logic [7:0]  confidence_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] note_start_o,
  output logic [31:0] note_end_o,
  output logic [15:0] mean_pitch_q4_o,
  output logic [6:0]  midi_note_o
);

  logic                 push, pop, q_full, q_empty, in_note;
  nsf_pkg::job_t        push_job, pop_job;
  nsf_pkg::back_state_e back_state;

  nsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_time_i (frame_time_i),
    .pitch_q4_i   (pitch_q4_i),
    .confidence_i (confidence_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job),
    .in_note_o    (in_note)
  );

  nsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  nsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .job_i           (pop_job),
    .pop_o           (pop),
    .state_o         (back_state),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .note_start_o    (note_start_o),
    .note_end_o      (note_end_o),
    .mean_pitch_q4_o (mean_pitch_q4_o),
    .midi_note_o     (midi_note_o)
  );

  `NSF_ASSERT_SAME(a_push_not_full, clk_i, rst_ni, push, !q_full, "job pushed into full queue")
  `NSF_ASSERT_SAME(a_pop_when_idle, clk_i, rst_ni, pop,
                   (back_state == nsf_pkg::ST_IDLE) && !q_empty, "job popped while busy")
  `NSF_ASSERT_NEXT(a_voiced_opens, clk_i, rst_ni,
                   in_valid_i && in_ready_o && (pitch_q4_i != 16'd0) && !in_note && push,
                   1'b0, "note pushed while no run was open")

endmodule

FILE: hw/rtl/nsf_front.sv
// Front end: configuration registers, voicing decision and run tracking.
// Emits one finished-note job per qualifying run; depends on nsf_pkg.
module nsf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        frame_time_i,
  input  logic [15:0]        pitch_q4_i,
  input  logic [7:0]         confidence_i,
  input  logic               q_full_i,
  output logic               push_o,
  output nsf_pkg::job_t      job_o,
  output logic               in_note_o
);

  logic [7:0]                     threshold_q;
  logic [15:0]                    min_frames_q;
  logic                           in_note_q, in_note_d;
  logic [nsf_pkg::STAMP_BITS-1:0] start_q, start_d;
  logic [nsf_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [31:0]                    sum_q, sum_d;
  logic                           accept, voiced;
  logic [32:0]                    sum_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign voiced     = (pitch_q4_i != 16'd0) && (confidence_i > threshold_q);
  assign sum_ext    = {1'b0, sum_q} + {17'd0, pitch_q4_i};

  always_comb begin
    in_note_d = in_note_q;
    start_d   = start_q;
    count_d   = count_q;
    sum_d     = sum_q;
    push_o    = 1'b0;
    if (accept) begin
      if (voiced) begin
        in_note_d = 1'b1;
        if (!in_note_q) begin
          start_d = nsf_pkg::STAMP_BITS'(frame_time_i);
          count_d = nsf_pkg::COUNT_BITS'(1);
          sum_d   = {16'd0, pitch_q4_i};
        end else begin
          if (count_q != nsf_pkg::COUNT_MAX) begin
            count_d = count_q + nsf_pkg::COUNT_BITS'(1);
          end
          sum_d = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        end
      end else begin
        in_note_d = 1'b0;
        push_o    = in_note_q && (32'(count_q) > 32'(min_frames_q));
      end
    end
  end

  assign job_o.start_stamp  = start_q;
  assign job_o.stop_stamp   = frame_time_i;
  assign job_o.pitch_sum    = sum_q;
  assign job_o.voiced_count = count_q;
  assign in_note_o          = in_note_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= nsf_pkg::THRESHOLD_RESET;
      min_frames_q <= nsf_pkg::MIN_FRAMES_RESET;
      in_note_q    <= 1'b0;
      start_q      <= '0;
      count_q      <= '0;
      sum_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          nsf_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_wdata_i[7:0];
          nsf_pkg::CFG_MIN_FRAMES: min_frames_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      in_note_q <= in_note_d;
      start_q   <= start_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
    end
  end

endmodule

FILE: hw/rtl/nsf_queue.sv
// Short job queue between the front end and the back end.
// Flip-flop storage of nsf_pkg::QUEUE_DEPTH jobs; depends on nsf_pkg.
module nsf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nsf_pkg::job_t job_i,
  input  logic          pop_i,
  output nsf_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);

  nsf_pkg::job_t                 mem_q [nsf_pkg::QUEUE_DEPTH];
  logic [nsf_pkg::QPTR_BITS-1:0] wr_q, rd_q;
  logic [nsf_pkg::QCNT_BITS-1:0] cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == nsf_pkg::QCNT_BITS'(nsf_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  function automatic logic [nsf_pkg::QPTR_BITS-1:0] ptr_next(
    input logic [nsf_pkg::QPTR_BITS-1:0] p
  );
    if (p == nsf_pkg::QPTR_BITS'(nsf_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + nsf_pkg::QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= ptr_next(wr_q);
      end
      if (do_pop) begin
        rd_q <= ptr_next(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + nsf_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - nsf_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/nsf_back.sv
// Back end: serial divide for the mean pitch, normalize, semitone lookup.
// Holds the result in an output register; depends on nsf_pkg.
module nsf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  nsf_pkg::job_t         job_i,
  output logic                  pop_o,
  output nsf_pkg::back_state_e  state_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           note_start_o,
  output logic [31:0]           note_end_o,
  output logic [15:0]           mean_pitch_q4_o,
  output logic [6:0]            midi_note_o
);

  localparam int CB = nsf_pkg::COUNT_BITS;

  nsf_pkg::back_state_e state_q, state_d;
  logic [31:0]   dvd_q;
  logic [CB-1:0] dvs_q;
  logic [CB-1:0] rem_q;
  logic [4:0]    step_q;
  logic [31:0]   start_q, stop_q;
  logic [15:0]   mean_q, x_q;
  logic [3:0]    e_q;
  logic [CB:0]   trial;
  logic          fits;
  logic [16:0]   mant;
  logic [3:0]    k;
  logic [7:0]    n;
  logic [6:0]    midi_c;
  logic          load_out;
  logic          out_valid_q;

  assign trial  = {rem_q, dvd_q[31]};
  assign fits   = (trial >= {1'b0, dvs_q});

  always_comb begin
    mant = {x_q, 1'b0};
    k = '0;
    for (int j = 0; j < 12; j++) begin
      k = k + 4'(mant >= nsf_pkg::SEMI_EDGE[j]);
    end
    n = 8'(e_q) * 8'd12 + 8'(k);
    if (mean_q == 16'd0 || n < nsf_pkg::MIDI_OFFSET) begin
      midi_c = '0;
    end else begin
      midi_c = 7'(n - nsf_pkg::MIDI_OFFSET);
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      nsf_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = nsf_pkg::ST_DIV;
        end
      end
      nsf_pkg::ST_DIV: begin
        if (step_q == 5'd31) begin
          state_d = nsf_pkg::ST_NORM;
        end
      end
      nsf_pkg::ST_NORM: begin
        if (x_q[15] || e_q == 4'd0) begin
          state_d = nsf_pkg::ST_FIN;
        end
      end
      nsf_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = nsf_pkg::ST_IDLE;
        end
      end
      default: state_d = nsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nsf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nsf_pkg::ST_IDLE: begin
        dvd_q   <= job_i.pitch_sum;
        dvs_q   <= job_i.voiced_count;
        rem_q   <= '0;
        step_q  <= '0;
        start_q <= 32'(job_i.start_stamp);
        stop_q  <= job_i.stop_stamp;
      end
      nsf_pkg::ST_DIV: begin
        rem_q  <= fits ? CB'(trial - {1'b0, dvs_q}) : trial[CB-1:0];
        dvd_q  <= {dvd_q[30:0], fits};
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          mean_q <= ((dvd_q[30:15] != 16'd0) ? 16'hFFFF : {dvd_q[14:0], fits});
          x_q    <= ((dvd_q[30:15] != 16'd0) ? 16'hFFFF : {dvd_q[14:0], fits});
          e_q    <= 4'd15;
        end
      end
      nsf_pkg::ST_NORM: begin
        if (!x_q[15] && e_q != 4'd0) begin
          x_q <= {x_q[14:0], 1'b0};
          e_q <= e_q - 4'd1;
        end
      end
      nsf_pkg::ST_FIN: begin
        if (load_out) begin
          note_start_o    <= start_q;
          note_end_o      <= stop_q;
          mean_pitch_q4_o <= mean_q;
          midi_note_o     <= midi_c;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign state_o     = state_q;

endmodule

FILE: tb/tb_note_segmenter_from_pitch_frames_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for note_segmenter_from_pitch_frames_core: directed and random
// pitch frames are checked against a built-in note predictor, with random stalls on both sides.
// Depends on nsf_pkg and the RTL of the note segmenter.
module tb_note_segmenter_from_pitch_frames_core;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int LONG_RUN_FRAMES = 40;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  // Q1.16 mantissa edges of the semitones, entry 0 in the low bits.
  localparam logic [12*17-1:0] SEMITONE_EDGES = {
    17'd130139, 17'd122835, 17'd115941, 17'd109434, 17'd103292, 17'd97495,
    17'd92023, 17'd86858, 17'd81983, 17'd77382, 17'd73039, 17'd68939
  };

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [15:0] mean;
    logic [6:0]  midi;
  } note_t;

  class note_predictor;
    logic [7:0]  threshold;
    logic [15:0] min_frames;
    bit          run_open;
    logic [31:0] run_start;
    logic [15:0] run_count;
    logic [31:0] run_sum;
    note_t       expected_notes[$];
    int          mismatches;

    function new();
      threshold = 8'd153;
      min_frames = 16'd10;
      run_open = 1'b0;
      run_start = '0;
      run_count = '0;
      run_sum = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] value);
      if (index == nsf_pkg::CFG_THRESHOLD) begin
        threshold = value[7:0];
      end else if (index == nsf_pkg::CFG_MIN_FRAMES) begin
        min_frames = value;
      end
    endfunction

    function logic [6:0] nearest_midi(logic [15:0] mean);
      int top;
      int note;
      logic [16:0] mant;
      if (mean == '0) return '0;
      top = 15;
      while (top > 0 && !mean[top]) top--;
      mant = {1'b0, mean} << (16 - top);
      note = 12 * top - 84;
      for (int i = 0; i < 12; i++) begin
        if (mant >= SEMITONE_EDGES[i*17 +: 17]) note++;
      end
      if (note < 0) note = 0;
      if (note > 127) note = 127;
      return 7'(note);
    endfunction

    function void take_frame(logic [31:0] stamp, logic [15:0] pitch, logic [7:0] conf);
      logic [32:0] sum_next;
      logic [31:0] mean_full;
      note_t n;
      if (pitch != '0 && conf > threshold) begin
        if (!run_open) begin
          run_open = 1'b1;
          run_start = stamp;
          run_count = '0;
          run_sum = '0;
        end
        if (run_count != '1) run_count++;
        sum_next = {1'b0, run_sum} + pitch;
        run_sum = sum_next[32] ? '1 : sum_next[31:0];
      end else begin
        if (run_open && run_count > min_frames) begin
          mean_full = run_sum / run_count;
          n.start = run_start;
          n.stop = stamp;
          n.mean = (mean_full > 32'hFFFF) ? 16'hFFFF : mean_full[15:0];
          n.midi = nearest_midi(n.mean);
          expected_notes.insert(expected_notes.size(), n);
        end
        run_open = 1'b0;
      end
    endfunction

    function void match_note(note_t got);
      note_t want;
      if (expected_notes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected note start=%h end=%h mean=%h midi=%0d",
                   $time, got.start, got.stop, got.mean, got.midi);
        return;
      end
      want = expected_notes.pop_front();
      if (got.start !== want.start || got.stop !== want.stop ||
          got.mean !== want.mean || got.midi !== want.midi) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: note mismatch: expected start=%h end=%h mean=%h midi=%0d",
                   $time, want.start, want.stop, want.mean, want.midi);
          $display("%0t: note mismatch: got      start=%h end=%h mean=%h midi=%0d",
                   $time, got.start, got.stop, got.mean, got.midi);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = nsf_pkg::CFG_THRESHOLD;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] frame_time_i = '0;
  logic [15:0] pitch_q4_i = '0;
  logic [7:0]  confidence_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] note_start_o;
  logic [31:0] note_end_o;
  logic [15:0] mean_pitch_q4_o;
  logic [6:0]  midi_note_o;

  note_predictor notes;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holdoff_request = 0;
  int          quiet_cycles = 0;
  logic [7:0]  cur_thr = 8'd153;
  logic [15:0] cur_min = 16'd10;
  logic [31:0] stamp_now = '0;

  note_segmenter_from_pitch_frames_core i_dut (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("note_segmenter_from_pitch_frames_core test failed");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    note_t got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{start: note_start_o, stop: note_end_o, mean: mean_pitch_q4_o,
                midi: midi_note_o};
        notes.match_note(got);
      end
      if (holdoff_request > 0) begin
        hold_left = holdoff_request;
        holdoff_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 15) == 0) begin
      stamp_now = $urandom();
    end else begin
      stamp_now++;
    end
    return stamp_now;
  endfunction

  task automatic send_frame(input logic [31:0] stamp, input logic [15:0] pitch,
                            input logic [7:0] conf);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_time_i <= stamp;
    pitch_q4_i <= pitch;
    confidence_i <= conf;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    notes.take_frame(stamp, pitch, conf);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (notes.expected_notes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] thr, input logic [15:0] minf);
    logic [15:0] thr_word;
    logic [15:0] spare_word;
    logic [1:0]  spare_index;
    thr_word = {8'($urandom()), thr};
    spare_word = 16'($urandom());
    spare_index = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= nsf_pkg::CFG_THRESHOLD;
    cfg_wdata_i <= thr_word;
    @(posedge clk_i);
    notes.write_reg(nsf_pkg::CFG_THRESHOLD, thr_word);
    cfg_index_i <= nsf_pkg::CFG_MIN_FRAMES;
    cfg_wdata_i <= minf;
    @(posedge clk_i);
    notes.write_reg(nsf_pkg::CFG_MIN_FRAMES, minf);
    // Writes to the unused indexes must leave both registers alone.
    cfg_index_i <= spare_index;
    cfg_wdata_i <= spare_word;
    @(posedge clk_i);
    notes.write_reg(spare_index, spare_word);
    cfg_we_i <= 1'b0;
    cur_thr = thr;
    cur_min = minf;
  endtask

  task automatic run_directed();
    // A confidence equal to the threshold and a zero pitch are both unvoiced.
    send_frame(32'h0000_0000, 16'd100, 8'd153);
    send_frame(32'h0000_0001, 16'd0, 8'd255);
    // Eleven voiced frames pass the default minimum of ten and close into a note.
    for (int i = 0; i < 11; i++) begin
      send_frame(32'hFFFF_FFF0 + 32'(i), (i % 2 == 0) ? 16'hFFFF : 16'd1,
                 (i % 2 == 0) ? 8'd154 : 8'd255);
    end
    send_frame(32'hFFFF_FFFF, 16'hFFFF, 8'd0);
    // Single-frame notes at the lowest pitch, at A4 and at the highest pitch.
    set_config(8'd0, 16'd0);
    send_frame(32'd100, 16'd1, 8'd1);
    send_frame(32'd101, 16'd5, 8'd0);
    send_frame(32'd102, 16'd7040, 8'd128);
    send_frame(32'd103, 16'd0, 8'd255);
    send_frame(32'd104, 16'hFFFF, 8'd255);
    send_frame(32'd105, 16'd0, 8'd0);
  endtask

  task automatic run_unreachable_min();
    // Under the largest minimum a long run stays open without reaching it.
    set_config(8'd0, 16'hFFFF);
    for (int i = 0; i < LONG_RUN_FRAMES; i++) send_frame(next_stamp(), 16'hFFFF, 8'hFF);
    // A lower minimum written while the run is open lets it close into a note.
    set_config(8'd0, 16'd20);
    send_frame(next_stamp(), 16'hFFFF, 8'd1);
    send_frame(next_stamp(), 16'hFFFF, 8'd0);
  endtask

  task automatic run_phase(input int ph);
    logic [7:0]  thr;
    logic [15:0] minf;
    logic [15:0] center;
    logic [15:0] pitch;
    logic [7:0]  conf;
    int          sent;
    int          len;
    int          lo;
    case (ph)
      0: begin thr = 8'd153; minf = 16'd10; end
      1: begin thr = 8'd0; minf = 16'd0; end
      2: begin thr = 8'd255; minf = 16'd3; end
      3: begin thr = 8'($urandom()); minf = 16'($urandom_range(0, 20)); end
      4: begin thr = 8'd200; minf = 16'd1; end
      5: begin thr = 8'd1; minf = 16'd5; end
      6: begin thr = 8'($urandom()); minf = 16'hFFFF; end
      default: begin thr = 8'($urandom()); minf = 16'($urandom_range(0, 30)); end
    endcase
    set_config(thr, minf);
    case (ph % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 75; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 75; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
    // Short notes and a receiver that stops for a long while fill the job queue.
    if (ph == 4) holdoff_request = HOLDOFF_CYCLES;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        if (cur_min > 40) begin
          len = $urandom_range(1, 12);
        end else begin
          lo = (cur_min > 2) ? int'(cur_min) - 2 : 1;
          len = $urandom_range(lo, int'(cur_min) + 6);
        end
        center = 16'($urandom()) >> $urandom_range(0, 12);
        if (center == '0) center = 16'd1;
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) begin
            pitch = 16'($urandom_range(1, 65535));
          end else begin
            pitch = center ^ 16'($urandom_range(0, 3));
          end
          if (pitch == '0) pitch = 16'd1;
          conf = (cur_thr == 8'hFF) ? 8'hFF : 8'($urandom_range(int'(cur_thr) + 1, 255));
          send_frame(next_stamp(), pitch, conf);
        end
        if ($urandom_range(0, 1)) begin
          send_frame(next_stamp(), 16'd0, 8'($urandom()));
        end else begin
          send_frame(next_stamp(), 16'($urandom()), 8'($urandom_range(0, int'(cur_thr))));
        end
        sent += len + 1;
      end else begin
        pitch = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom());
        send_frame(next_stamp(), pitch, 8'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    notes = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_unreachable_min();
    for (int ph = 0; ph < PHASE_COUNT; ph++) run_phase(ph);
    wait_idle();
    if (notes.mismatches == 0 && notes.expected_notes.size() == 0) begin
      $display("note_segmenter_from_pitch_frames_core test passed");
    end else begin
      $display("note_segmenter_from_pitch_frames_core test failed");
    end
    $finish;
  end

endmodule
